[sv/mkmc_pkg.sv]
// mkmc_pkg: shared types, codes and helpers for the keyword match counter
// used by multi_keyword_match_counter_unit; no dependencies
package mkmc_pkg;

  localparam int NUM_KEYWORDS_DEF = 16;
  localparam int KEY_BYTES_DEF    = 16;

  localparam logic [3:0]  RANK_NONE = 4'd10;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TEXT = 2'd1,
    OP_END  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

[sv/multi_keyword_match_counter_unit.sv]
// multi_keyword_match_counter_unit: keyword table with per-byte multi-keyword matching
// one shared compare unit scans the keyword memory a keyword per cycle
// depends on mkmc_pkg
//
// sequencing: load, end-of-text and count read pass through the finish state, which registers their result
// once the output register is free; a text byte first scans min(keywords_in_use, NUM_KEYWORDS) keywords,
// one keyword row read from the keyword memory port and compared per cycle
// throughput: one item at a time, the next transfer is taken once the result is registered
// reset: synchronous, clears counts, window, lengths and keywords_in_use; no clearing pass
module multi_keyword_match_counter_unit #(
  parameter int NUM_KEYWORDS = mkmc_pkg::NUM_KEYWORDS_DEF,
  parameter int KEY_BYTES    = mkmc_pkg::KEY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [3:0]  keyword_index,
  input  logic [3:0]  char_pos,
  input  logic [7:0]  char_value,
  input  logic [4:0]  keyword_length,
  input  logic [7:0]  keyword_rank,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] total_matches,
  output logic [4:0]  matches_this_byte,
  output logic [3:0]  best_rank,
  output logic [31:0] keyword_hits
);

  localparam int KIW = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
  localparam int CW  = $clog2(NUM_KEYWORDS + 1);
  localparam int LW  = $clog2(KEY_BYTES + 1);
  localparam int WIW = $clog2(KEY_BYTES);
  localparam int RW  = KEY_BYTES * 8;

  // control state
  mkmc_pkg::state_t state, state_next;
  logic [4:0]       keywords_in_use;
  logic [CW-1:0]    rd_k;
  logic             cmp_v;
  logic [KIW-1:0]   cmp_k;
  logic [LW-1:0]    window_fill;
  logic [31:0]      match_total;
  logic [3:0]       lowest_rank;
  logic [4:0]       byte_count;
  logic [NUM_KEYWORDS-1:0] meta_valid;
  logic [NUM_KEYWORDS-1:0] hit_valid;

  // item and snapshot registers
  mkmc_pkg::op_t    op_q;
  logic             hit_ok_q;
  logic [31:0]      snap_total;
  logic [3:0]       snap_rank;
  logic [7:0]       text_window [KEY_BYTES];

  // memories and their read registers
  logic [RW-1:0]    key_mem  [NUM_KEYWORDS];
  logic [LW+7:0]    meta_mem [NUM_KEYWORDS];
  logic [31:0]      hit_mem  [NUM_KEYWORDS];
  logic [RW-1:0]    row_q;
  logic [7:0]       rank_q;
  logic [LW-1:0]    len_q;
  logic             meta_valid_q;
  logic [31:0]      hit_q;
  logic             hit_valid_q;

  // control
  mkmc_pkg::op_t    op_in;
  logic             accept;
  logic             idx_ok;
  logic [KIW-1:0]   idx_addr;
  logic [LW-1:0]    len_clamped;
  logic [CW-1:0]    active;
  logic             issue;
  logic             finish_load;
  logic             load_we;
  logic             hit_rd_en;
  logic [KIW-1:0]   hit_rd_addr;
  logic [LW-1:0]    eff_len;
  logic             bytes_ok;
  logic             match;
  logic [31:0]      hit_new;

  assign op_in    = mkmc_pkg::op_t'(op);
  assign accept   = in_valid && in_ready;
  assign idx_ok   = int'(keyword_index) < NUM_KEYWORDS;
  assign idx_addr = KIW'(keyword_index);
  assign len_clamped = (int'(keyword_length) > KEY_BYTES) ? LW'(KEY_BYTES)
                                                          : LW'(keyword_length);
  assign active = (int'(keywords_in_use) > NUM_KEYWORDS) ? CW'(NUM_KEYWORDS)
                                                         : CW'(keywords_in_use);
  assign load_we     = accept && (op_in == mkmc_pkg::OP_LOAD) && idx_ok;
  assign hit_rd_en   = issue || (accept && (op_in == mkmc_pkg::OP_READ));
  assign hit_rd_addr = issue ? rd_k[KIW-1:0] : idx_addr;

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      mkmc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (op_in == mkmc_pkg::OP_TEXT) ? mkmc_pkg::ST_SCAN
                                                    : mkmc_pkg::ST_FINISH;
        end
      end
      mkmc_pkg::ST_SCAN: begin
        if (rd_k == active && !cmp_v) begin
          state_next = mkmc_pkg::ST_FINISH;
        end
      end
      mkmc_pkg::ST_FINISH: begin
        if (finish_load) begin
          state_next = mkmc_pkg::ST_IDLE;
        end
      end
      default: state_next = mkmc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    issue       = 1'b0;
    finish_load = 1'b0;
    case (state)
      mkmc_pkg::ST_IDLE:   in_ready = 1'b1;
      mkmc_pkg::ST_SCAN:   issue = (rd_k < active);
      mkmc_pkg::ST_FINISH: finish_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // shared compare unit: one keyword row against the window ending at the newest byte
  always_comb begin
    eff_len  = meta_valid_q ? len_q : '0;
    bytes_ok = 1'b1;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (i < int'(eff_len)) begin
        if (row_q[i*8 +: 8] != text_window[WIW'(int'(eff_len) - 1 - i)]) begin
          bytes_ok = 1'b0;
        end
      end
    end
    match   = cmp_v && (eff_len != '0) && (eff_len <= window_fill) && bytes_ok;
    hit_new = mkmc_pkg::sat_inc(hit_valid_q ? hit_q : 32'd0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= mkmc_pkg::ST_IDLE;
      keywords_in_use <= '0;
      rd_k            <= '0;
      cmp_v           <= 1'b0;
      window_fill     <= '0;
      match_total     <= '0;
      lowest_rank     <= mkmc_pkg::RANK_NONE;
      byte_count      <= '0;
      meta_valid      <= '0;
      hit_valid       <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        keywords_in_use <= cfg_wdata;
      end
      if (load_we) begin
        meta_valid[idx_addr] <= 1'b1;
      end
      cmp_v <= issue;
      if (issue) begin
        rd_k <= rd_k + CW'(1);
      end
      if (accept && op_in == mkmc_pkg::OP_TEXT) begin
        rd_k       <= '0;
        byte_count <= '0;
        if (window_fill < LW'(KEY_BYTES)) begin
          window_fill <= window_fill + LW'(1);
        end
      end
      if (accept && op_in == mkmc_pkg::OP_END) begin
        match_total <= '0;
        lowest_rank <= mkmc_pkg::RANK_NONE;
        window_fill <= '0;
        hit_valid   <= '0;
      end
      if (match) begin
        hit_valid[cmp_k] <= 1'b1;
        match_total      <= mkmc_pkg::sat_inc(match_total);
        byte_count       <= byte_count + 5'd1;
        if (rank_q < {4'b0, lowest_rank}) begin
          lowest_rank <= rank_q[3:0];
        end
      end
      if (finish_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // text window, item and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_BYTES; i++) begin
        text_window[i] <= '0;
      end
    end else if (accept && op_in == mkmc_pkg::OP_TEXT) begin
      text_window[0] <= char_value;
      for (int i = 1; i < KEY_BYTES; i++) begin
        text_window[i] <= text_window[i-1];
      end
    end else if (accept && op_in == mkmc_pkg::OP_END) begin
      for (int i = 0; i < KEY_BYTES; i++) begin
        text_window[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= op_in;
      hit_ok_q   <= idx_ok;
      snap_total <= match_total;
      snap_rank  <= lowest_rank;
    end
    if (issue) begin
      cmp_k <= rd_k[KIW-1:0];
    end
    if (finish_load) begin
      total_matches     <= (op_q == mkmc_pkg::OP_END) ? snap_total : match_total;
      best_rank         <= (op_q == mkmc_pkg::OP_END) ? snap_rank : lowest_rank;
      matches_this_byte <= (op_q == mkmc_pkg::OP_TEXT) ? byte_count : 5'd0;
      keyword_hits      <= (op_q == mkmc_pkg::OP_READ && hit_ok_q && hit_valid_q)
                           ? hit_q : 32'd0;
    end
  end

  // keyword byte memory, one row per keyword, byte-lane writes
  always_ff @(posedge clk) begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (load_we && int'(char_pos) == i) begin
        key_mem[idx_addr][i*8 +: 8] <= char_value;
      end
    end
    if (issue) begin
      row_q <= key_mem[rd_k[KIW-1:0]];
    end
  end

  // length and rank memory
  always_ff @(posedge clk) begin
    if (load_we) begin
      meta_mem[idx_addr] <= {keyword_rank, len_clamped};
    end
    if (issue) begin
      {rank_q, len_q} <= meta_mem[rd_k[KIW-1:0]];
      meta_valid_q    <= meta_valid[rd_k[KIW-1:0]];
    end
  end

  // hit count memory
  always_ff @(posedge clk) begin
    if (match) begin
      hit_mem[cmp_k] <= hit_new;
    end
    if (hit_rd_en) begin
      hit_q       <= hit_mem[hit_rd_addr];
      hit_valid_q <= hit_valid[hit_rd_addr];
    end
  end

  a_end_clears_total: assert property (@(posedge clk) disable iff (rst)
    accept && op_in == mkmc_pkg::OP_END |=> match_total == 32'd0)
    else $error("total not cleared after end of text");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == mkmc_pkg::ST_SCAN |-> rd_k <= active)
    else $error("scan counter past active keywords");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_v |-> state == mkmc_pkg::ST_SCAN)
    else $error("compare stage busy outside scan");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    lowest_rank <= mkmc_pkg::RANK_NONE)
    else $error("best rank above none code");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    window_fill <= LW'(KEY_BYTES))
    else $error("window fill above key length");

endmodule

[tb/multi_keyword_match_counter_unit_tb.sv]
// testbench for multi_keyword_match_counter_unit: loads keyword tables, streams text
// and checks every result against an in-bench match predictor
// depends on mkmc_pkg and multi_keyword_match_counter_unit
module multi_keyword_match_counter_unit_tb;

  localparam int KEYS = mkmc_pkg::NUM_KEYWORDS_DEF;
  localparam int KBYTES = mkmc_pkg::KEY_BYTES_DEF;
  localparam int ITEM_TARGET = 1300;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] total;
    logic [4:0]  this_byte;
    logic [3:0]  rank;
    logic [31:0] hits;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = 5'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = 2'd0;
  logic [3:0]  keyword_index = 4'd0;
  logic [3:0]  char_pos = 4'd0;
  logic [7:0]  char_value = 8'd0;
  logic [4:0]  keyword_length = 5'd0;
  logic [7:0]  keyword_rank = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] total_matches;
  logic [4:0]  matches_this_byte;
  logic [3:0]  best_rank;
  logic [31:0] keyword_hits;

  // predictor state
  logic [7:0]  kw_bytes [KEYS][KBYTES];
  logic [4:0]  kw_len [KEYS] = '{default: 5'd0};
  logic [7:0]  kw_rank [KEYS];
  logic [31:0] kw_hits [KEYS];
  logic [31:0] match_total;
  logic [7:0]  text_win [KBYTES];
  int          win_fill;
  logic [7:0]  lowest_rank;
  int          kw_in_use = 0;

  scan_result_t pending_results[$];
  int mismatch_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  logic [7:0] alpha [4];
  int alpha_n = 1;

  int ready_mode = 0;
  int mode_left = 0;
  int tick = 0;

  multi_keyword_match_counter_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .keyword_index(keyword_index),
    .char_pos(char_pos),
    .char_value(char_value),
    .keyword_length(keyword_length),
    .keyword_rank(keyword_rank),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .total_matches(total_matches),
    .matches_this_byte(matches_this_byte),
    .best_rank(best_rank),
    .keyword_hits(keyword_hits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_text_state();
    int i;
    for (i = 0; i < KEYS; i++) kw_hits[i] = 32'd0;
    for (i = 0; i < KBYTES; i++) text_win[i] = 8'd0;
    match_total = 32'd0;
    win_fill = 0;
    lowest_rank = {4'd0, mkmc_pkg::RANK_NONE};
  endfunction

  function automatic scan_result_t predict_scan(mkmc_pkg::op_t o, logic [3:0] idx,
                                                logic [3:0] pos, logic [7:0] val,
                                                logic [4:0] len, logic [7:0] rnk);
    scan_result_t r;
    int active;
    int k;
    int i;
    bit hit;
    r.total = match_total;
    r.this_byte = 5'd0;
    r.rank = lowest_rank[3:0];
    r.hits = 32'd0;
    case (o)
      mkmc_pkg::OP_LOAD: begin
        kw_bytes[idx][pos] = val;
        kw_len[idx] = (len > KBYTES) ? 5'(KBYTES) : len;
        kw_rank[idx] = rnk;
      end
      mkmc_pkg::OP_TEXT: begin
        active = (kw_in_use > KEYS) ? KEYS : kw_in_use;
        for (i = KBYTES - 1; i > 0; i--) text_win[i] = text_win[i - 1];
        text_win[0] = val;
        if (win_fill < KBYTES) win_fill++;
        for (k = 0; k < active; k++) begin
          hit = (kw_len[k] != 0) && (kw_len[k] <= win_fill);
          for (i = 0; hit && i < kw_len[k]; i++) begin
            if (kw_bytes[k][i] != text_win[kw_len[k] - 1 - i]) hit = 1'b0;
          end
          if (hit) begin
            r.this_byte = r.this_byte + 5'd1;
            if (kw_hits[k] != mkmc_pkg::COUNT_MAX) kw_hits[k] = kw_hits[k] + 32'd1;
            if (match_total != mkmc_pkg::COUNT_MAX) match_total = match_total + 32'd1;
            if (kw_rank[k] < lowest_rank) lowest_rank = kw_rank[k];
          end
        end
        r.total = match_total;
        r.rank = lowest_rank[3:0];
      end
      mkmc_pkg::OP_END: begin
        clear_text_state();
      end
      default: begin
        r.hits = kw_hits[idx];
      end
    endcase
    return r;
  endfunction

  function automatic void report_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      tick <= tick + 1;
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(40, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ((tick % 5) == 0);
        default: out_ready <= ((tick % 23) >= 18);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    scan_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result: total=%0d byte=%0d rank=%0d hits=%0d",
                               total_matches, matches_this_byte, best_rank, keyword_hits));
      end else begin
        want = pending_results.pop_front();
        if (want.total !== total_matches || want.this_byte !== matches_this_byte ||
            want.rank !== best_rank || want.hits !== keyword_hits) begin
          report_error($sformatf({"mismatch: expected total=%0d byte=%0d rank=%0d hits=%0d,",
                                  " got total=%0d byte=%0d rank=%0d hits=%0d"},
                                 want.total, want.this_byte, want.rank, want.hits,
                                 total_matches, matches_this_byte, best_rank, keyword_hits));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("no transfer for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input mkmc_pkg::op_t o, input logic [3:0] idx,
                           input logic [3:0] pos, input logic [7:0] val,
                           input logic [4:0] len, input logic [7:0] rnk);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 10);
      burst_left = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    pending_results.insert(pending_results.size(), predict_scan(o, idx, pos, val, len, rnk));
    in_valid <= 1'b1;
    op <= o;
    keyword_index <= idx;
    char_pos <= pos;
    char_value <= val;
    keyword_length <= len;
    keyword_rank <= rnk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_load(input logic [3:0] idx, input logic [3:0] pos,
                           input logic [7:0] val, input logic [4:0] len,
                           input logic [7:0] rnk);
    send_item(mkmc_pkg::OP_LOAD, idx, pos, val, len, rnk);
  endtask

  task automatic send_text(input logic [7:0] val);
    send_item(mkmc_pkg::OP_TEXT, 4'($urandom), 4'($urandom), val, 5'($urandom),
              8'($urandom));
  endtask

  task automatic send_end();
    send_item(mkmc_pkg::OP_END, 4'($urandom), 4'($urandom), 8'($urandom), 5'($urandom),
              8'($urandom));
  endtask

  task automatic send_read(input logic [3:0] idx);
    send_item(mkmc_pkg::OP_READ, idx, 4'($urandom), 8'($urandom), 5'($urandom),
              8'($urandom));
  endtask

  task automatic wait_drained();
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [4:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    kw_in_use = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    return alpha[$urandom_range(0, alpha_n - 1)];
  endfunction

  function automatic logic [4:0] pick_length();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 5'($urandom_range(1, 4));
    if (sel < 85) return 5'($urandom_range(5, 16));
    if (sel < 93) return 5'd0;
    return 5'($urandom_range(17, 31));
  endfunction

  function automatic logic [4:0] pick_in_use();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return 5'd0;
    if (sel < 20) return 5'd16;
    if (sel < 28) return 5'd31;
    if (sel < 38) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(1, 16));
  endfunction

  task automatic load_keyword(input logic [3:0] idx, input logic [4:0] len,
                              input logic [7:0] rnk);
    int n;
    int p;
    n = (len > KBYTES) ? KBYTES : len;
    for (p = 0; p < n; p++) send_load(idx, 4'(p), pick_byte(), len, rnk);
    if (n == 0 || $urandom_range(0, 4) == 0)
      send_load(idx, 4'($urandom), 8'($urandom), len, rnk);
  endtask

  task automatic send_keyword_text(input int k);
    int n;
    int i;
    n = kw_len[k];
    for (i = 0; i < n; i++) send_text(kw_bytes[k][i]);
  endtask

  // every keyword byte gets written once so no undefined byte is ever compared
  task automatic test_table_fill();
    int k;
    int p;
    gaps_on = 1'b1;
    for (k = 0; k < KEYS; k++) begin
      for (p = 0; p < KBYTES; p++) begin
        send_load(4'(k), 4'(p), 8'($urandom), (p == KBYTES - 1) ? 5'd0 : 5'($urandom),
                  8'($urandom));
      end
    end
  endtask

  task automatic test_directed_cases();
    cfg_write(5'd3);
    send_load(4'd0, 4'd0, 8'h00, 5'd2, 8'd0);
    send_load(4'd0, 4'd1, 8'hFF, 5'd2, 8'd0);
    send_load(4'd1, 4'd0, 8'hFF, 5'd1, 8'hFF);
    // overlong length clipped to a full-width keyword
    send_load(4'd2, 4'd15, 8'hA5, 5'd31, 8'd9);
    // short window: two-byte keyword cannot match on the first byte
    send_text(8'hFF);
    send_text(8'h00);
    send_text(8'hFF);
    send_read(4'd0);
    send_read(4'd1);
    send_read(4'd15);
    send_end();
    send_read(4'd0);
    // zero length disables the keyword
    send_load(4'd1, 4'd0, 8'hFF, 5'd0, 8'd3);
    send_text(8'hFF);
    send_end();
    // in-use count above the table size
    cfg_write(5'd31);
    send_load(4'd15, 4'd0, 8'hFF, 5'd1, 8'd5);
    send_text(8'hFF);
    send_text(8'hFF);
    send_read(4'd15);
    send_end();
    cfg_write(5'd16);
    send_text(8'hFF);
    send_end();
    cfg_write(5'd0);
    send_text(8'hFF);
    send_end();
  endtask

  task automatic test_random_scan();
    int i;
    int n_text;
    int sel;
    while (items_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      cfg_write(pick_in_use());
      alpha_n = $urandom_range(1, 4);
      for (i = 0; i < alpha_n; i++) begin
        sel = $urandom_range(0, 5);
        alpha[i] = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
      end
      repeat ($urandom_range(1, 4)) begin
        load_keyword(4'($urandom), pick_length(),
                     ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 11)) : 8'($urandom));
      end
      n_text = $urandom_range(4, 40);
      for (i = 0; i < n_text; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 12) send_keyword_text($urandom_range(0, KEYS - 1));
        else if (sel < 17) send_read(4'($urandom));
        else if (sel < 20)
          send_item(mkmc_pkg::op_t'($urandom_range(0, 3)), 4'($urandom), 4'($urandom),
                    8'($urandom), 5'($urandom), 8'($urandom));
        else if (sel < 27) send_text(8'($urandom));
        else send_text(pick_byte());
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
      repeat ($urandom_range(0, 2)) send_read(4'($urandom));
      if ($urandom_range(0, 9) != 0) send_end();
    end
  endtask

  initial begin
    clear_text_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_table_fill();
    test_directed_cases();
    test_random_scan();
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[multi_keyword_match_counter_unit.f]
sv/mkmc_pkg.sv
sv/multi_keyword_match_counter_unit.sv
tb/multi_keyword_match_counter_unit_tb.sv
